[hdl/ray_triangle_closest_hit_assert.svh]
// Assertion macros shared by the ray/triangle closest-hit RTL.
// Depends on nothing; a file that asserts includes it by name.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_ASSERT_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_ASSERT_SVH
`ifndef SYNTH
`define RTCH_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("rtch implication check failed");
`define RTCH_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("rtch next-cycle check failed");
`else
`define RTCH_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define RTCH_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

[hdl/rtch_pkg.sv]
// Package for the ray/triangle closest-hit block: types, constants,
// the micro-program of the shared multiplier and saturation helpers.
// Depends on nothing.
package rtch_pkg;

    localparam int MAX_TRIANGLES = 1024;
    localparam int FRAC_BITS     = 16;
    localparam int WORD_W        = 32;
    localparam int TRI_W         = 10;
    localparam int CNT_W         = 11;
    localparam int ROW_W         = 3 * WORD_W;
    localparam int ROWS          = MAX_TRIANGLES * 3;
    localparam int ADDR_W        = $clog2(ROWS);
    localparam int PROD_W        = 2 * WORD_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int DVD_W         = WORD_W + FRAC_BITS;

    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;
    localparam longint Q_ONE = 64'sd1 <<< FRAC_BITS;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAST = 1'b1;
    localparam logic [1:0] CORNER_NONE = 2'd3;
    localparam logic [1:0] RDK_LAST    = 2'd3;
    localparam logic [1:0] DIVK_LAST   = 2'd2;
    localparam logic [1:0] HP_LAST     = 2'd3;

    // Register file slots used by the shared multiplier.
    localparam int RF_N    = 29;
    localparam int RF_W    = $clog2(RF_N);
    localparam int RF_NDIR = 0;
    localparam int RF_E1   = 3;
    localparam int RF_E2   = 6;
    localparam int RF_B    = 9;
    localparam int RF_C    = 12;
    localparam int RF_P    = 15;
    localparam int RF_Q    = 18;
    localparam int RF_DIR  = 21;
    localparam int RF_DET  = 24;
    localparam int RF_TN   = 25;
    localparam int RF_BEST = 28;

    localparam int MINORS = 9;
    localparam int DOTS   = 4;
    localparam int UC_LEN = 2 * MINORS + 3 * DOTS + 1;
    localparam int UC_W   = $clog2(UC_LEN);

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_MINOR,
        ACT_DFIRST,
        ACT_DADD,
        ACT_DLAST
    } t_act;

    typedef struct packed {
        logic [RF_W-1:0] a;
        logic [RF_W-1:0] b;
        t_act            act;
        logic [RF_W-1:0] dst;
    } t_uop;

    typedef t_uop [UC_LEN-1:0] t_ucode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EDGE,
        S_CALC,
        S_DIV,
        S_CMP,
        S_HP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                     op;
        logic [TRI_W-1:0]         tri_index;
        logic [1:0]               corner;
        logic signed [WORD_W-1:0] point_x;
        logic signed [WORD_W-1:0] point_y;
        logic signed [WORD_W-1:0] point_z;
        logic signed [WORD_W-1:0] dir_x;
        logic signed [WORD_W-1:0] dir_y;
        logic signed [WORD_W-1:0] dir_z;
    } t_in_item;

    typedef struct packed {
        logic                     hit;
        logic [TRI_W-1:0]         hit_index;
        logic [WORD_W-2:0]        hit_distance;
        logic signed [WORD_W-1:0] hit_x;
        logic signed [WORD_W-1:0] hit_y;
        logic signed [WORD_W-1:0] hit_z;
    } t_out_item;

    // Each minor is A*D - B*C.
    localparam int MIN_A [MINORS] = '{RF_E1+1, RF_E1+2, RF_E1+0, RF_B+1, RF_B+2, RF_B+0,
                                      RF_E1+1, RF_E1+2, RF_E1+0};
    localparam int MIN_B [MINORS] = '{RF_E1+2, RF_E1+0, RF_E1+1, RF_B+2, RF_B+0, RF_B+1,
                                      RF_E1+2, RF_E1+0, RF_E1+1};
    localparam int MIN_C [MINORS] = '{RF_E2+1, RF_E2+2, RF_E2+0, RF_E2+1, RF_E2+2, RF_E2+0,
                                      RF_B+1, RF_B+2, RF_B+0};
    localparam int MIN_D [MINORS] = '{RF_E2+2, RF_E2+0, RF_E2+1, RF_E2+2, RF_E2+0, RF_E2+1,
                                      RF_B+2, RF_B+0, RF_B+1};
    localparam int DOT_L [DOTS] = '{RF_NDIR, RF_B, RF_NDIR, RF_NDIR};
    localparam int DOT_R [DOTS] = '{RF_C, RF_C, RF_P, RF_Q};

    // Step s issues a product; its action consumes the product issued at s-1.
    function automatic t_ucode build_ucode();
        t_ucode uc;
        int     s;
        uc = '0;
        for (int j = 0; j < MINORS; j++) begin
            uc[2*j].a       = RF_W'(MIN_A[j]);
            uc[2*j].b       = RF_W'(MIN_D[j]);
            uc[2*j+1].a     = RF_W'(MIN_B[j]);
            uc[2*j+1].b     = RF_W'(MIN_C[j]);
            uc[2*j+1].act   = ACT_LOAD;
            uc[2*j+2].act   = ACT_MINOR;
            uc[2*j+2].dst   = RF_W'(RF_C + j);
        end
        for (int d = 0; d < DOTS; d++) begin
            for (int k = 0; k < 3; k++) begin
                s = 2 * MINORS + 3 * d + k;
                uc[s].a     = RF_W'(DOT_L[d] + k);
                uc[s].b     = RF_W'(DOT_R[d] + k);
                uc[s+1].act = (k == 0) ? ACT_DFIRST : ((k == 1) ? ACT_DADD : ACT_DLAST);
                if (k == 2) begin
                    uc[s+1].dst = RF_W'(RF_DET + d);
                end
            end
        end
        return uc;
    endfunction

    localparam t_ucode UCODE = build_ucode();

    function automatic logic signed [WORD_W-1:0] sat_w(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(W_MAX);
        lo = ACC_W'(W_MIN);
        if (x > hi) begin
            return WORD_W'(W_MAX);
        end else if (x < lo) begin
            return WORD_W'(W_MIN);
        end
        return x[WORD_W-1:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] row_word(input logic [ROW_W-1:0] row,
                                                          input logic [1:0] k);
        return row[k*WORD_W +: WORD_W];
    endfunction

endpackage

[hdl/ray_triangle_closest_hit.sv]
// Ray/triangle closest-hit search. A vertex load writes one corner row; a
// cast searches n triangles, each with three divisions (none for a singular
// one) through one shared divider and a micro-program pass of the shared
// 32x32 multiplier.
// Synchronous active-low reset clears control state and the triangle count;
// the vertex store is not cleared and needs no clearing pass.
`include "ray_triangle_closest_hit_assert.svh"
module ray_triangle_closest_hit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  rtch_pkg::t_in_item          i_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output rtch_pkg::t_out_item         o_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rtch_pkg::CNT_W-1:0]  i_cfg_data
);
    import rtch_pkg::*;

    // Control state.
    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_div_run, n_div_run;

    // Sequencer counters and datapath registers.
    logic [CNT_W-1:0]   r_n, n_n;
    logic [TRI_W-1:0]   r_tri, n_tri;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [1:0]         r_rdk, n_rdk;
    logic [UC_W-1:0]    r_step, n_step;
    logic [1:0]         r_divk, n_divk;
    logic [1:0]         r_hp, n_hp;
    logic               r_found, n_found;
    logic [TRI_W-1:0]   r_bidx, n_bidx;
    logic signed [WORD_W-1:0] r_org [3];
    logic signed [WORD_W-1:0] n_org [3];
    logic signed [WORD_W-1:0] r_hit [3];
    logic signed [WORD_W-1:0] n_hit [3];
    logic signed [WORD_W-1:0] r_quo [3];
    logic signed [WORD_W-1:0] n_quo [3];
    logic [ROW_W-1:0]   r_vtx [3];
    logic [ROW_W-1:0]   n_vtx [3];
    logic signed [WORD_W-1:0] r_rf [RF_N];
    logic signed [WORD_W-1:0] n_rf [RF_N];
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    t_out_item          r_out, n_out;

    // Strobes and shared-unit wiring.
    logic               in_acc;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ROW_W-1:0]   rd_data;
    logic               div_start;
    logic               div_done;
    logic signed [WORD_W-1:0] div_quo;
    logic               out_load;
    logic               last_tri;
    logic               det_zero;
    logic               hit_ok;
    logic [CNT_W-1:0]   cnt_lim;
    t_uop               uop;
    logic [RF_W-1:0]    sel_a, sel_b;
    logic signed [WORD_W-1:0] mul_a, mul_b;
    logic signed [WORD_W-1:0] qm;
    logic signed [WORD_W+1:0] uv_sum;

    rtch_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_item.point_z, i_item.point_y, i_item.point_x}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rtch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_rf[RF_TN + int'(r_divk)]),
        .i_den   (r_rf[RF_DET]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Conditions shared by the sequencer and the datapath.
    always_comb begin
        in_acc   = i_valid && !o_stall;
        cnt_lim  = (r_count > CNT_W'(MAX_TRIANGLES)) ? CNT_W'(MAX_TRIANGLES) : r_count;
        last_tri = (CNT_W'(r_tri) + CNT_W'(1)) == r_n;
        det_zero = r_rf[RF_DET] == '0;
        uv_sum   = (WORD_W+2)'(r_quo[1]) + (WORD_W+2)'(r_quo[2]);
        hit_ok   = (r_quo[1] >= 0) && (r_quo[2] >= 0) && (uv_sum <= (WORD_W+2)'(Q_ONE))
                   && (r_quo[0] > 0) && (r_quo[0] < r_rf[RF_BEST]);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_item.op == OP_CAST) begin
                    n_state = (cnt_lim == '0) ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                if (r_rdk == RDK_LAST) begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (r_step == UC_W'(UC_LEN - 1)) begin
                    if (!det_zero) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = last_tri ? S_HP : S_READ;
                    end
                end
            end
            S_DIV: begin
                if (div_done && r_divk == DIVK_LAST) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = last_tri ? S_HP : S_READ;
            end
            S_HP: begin
                if (!r_found || r_hp == HP_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_stall     = r_state != S_IDLE;
        o_cfg_ready = 1'b1;
        wr_en       = in_acc && i_item.op == OP_LOAD && i_item.corner != CORNER_NONE
                      && (CNT_W'(i_item.tri_index) < CNT_W'(MAX_TRIANGLES));
        wr_addr     = ADDR_W'({i_item.tri_index, 1'b0}) + ADDR_W'(i_item.tri_index)
                      + ADDR_W'(i_item.corner);
        rd_en       = r_state == S_READ && r_rdk != RDK_LAST;
        rd_addr     = r_base + ADDR_W'(r_rdk);
        div_start   = r_state == S_DIV && !r_div_run;
        out_load    = r_state == S_DONE && (!r_out_valid || !i_stall);
        o_valid     = r_out_valid;
        o_item      = r_out;
    end

    // Operand selection for the shared multiplier: the micro-program drives
    // it while the triangle is being solved, the hit-point pass afterwards.
    always_comb begin
        uop   = UCODE[r_step];
        sel_a = uop.a;
        sel_b = uop.b;
        if (r_state == S_HP) begin
            sel_a = RF_W'(RF_BEST);
            sel_b = RF_W'(RF_DIR) + RF_W'(r_hp);
        end
        mul_a = r_rf[sel_a];
        mul_b = r_rf[sel_b];
        qm    = sat_w(ACC_W'(r_prod) >>> FRAC_BITS);
    end

    // Datapath next values.
    always_comb begin
        n_out_valid = r_out_valid;
        n_count     = r_count;
        n_div_run   = r_div_run;
        n_n         = r_n;
        n_tri       = r_tri;
        n_base      = r_base;
        n_rdk       = r_rdk;
        n_step      = r_step;
        n_divk      = r_divk;
        n_hp        = r_hp;
        n_found     = r_found;
        n_bidx      = r_bidx;
        n_org       = r_org;
        n_hit       = r_hit;
        n_quo       = r_quo;
        n_vtx       = r_vtx;
        n_rf        = r_rf;
        n_acc       = r_acc;
        n_out       = r_out;
        n_prod      = mul_a * mul_b;

        if (i_cfg_valid && o_cfg_ready) begin
            n_count = i_cfg_data;
        end
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_item.op == OP_CAST) begin
                    n_org[0] = i_item.point_x;
                    n_org[1] = i_item.point_y;
                    n_org[2] = i_item.point_z;
                    n_rf[RF_DIR]      = i_item.dir_x;
                    n_rf[RF_DIR + 1]  = i_item.dir_y;
                    n_rf[RF_DIR + 2]  = i_item.dir_z;
                    n_rf[RF_NDIR]     = sat_w(-ACC_W'(i_item.dir_x));
                    n_rf[RF_NDIR + 1] = sat_w(-ACC_W'(i_item.dir_y));
                    n_rf[RF_NDIR + 2] = sat_w(-ACC_W'(i_item.dir_z));
                    n_rf[RF_BEST]     = WORD_W'(W_MAX);
                    n_found = 1'b0;
                    n_bidx  = '0;
                    n_tri   = '0;
                    n_base  = '0;
                    n_rdk   = '0;
                    n_hp    = '0;
                    n_n     = cnt_lim;
                end
            end
            S_READ: begin
                n_rdk = r_rdk + 1'b1;
                if (r_rdk != '0) begin
                    n_vtx[r_rdk - 1'b1] = rd_data;
                end
            end
            S_EDGE: begin
                for (int k = 0; k < 3; k++) begin
                    n_rf[RF_E1 + k] = sat_w(ACC_W'(row_word(r_vtx[1], 2'(k)))
                                            - ACC_W'(row_word(r_vtx[0], 2'(k))));
                    n_rf[RF_E2 + k] = sat_w(ACC_W'(row_word(r_vtx[2], 2'(k)))
                                            - ACC_W'(row_word(r_vtx[0], 2'(k))));
                    n_rf[RF_B + k]  = sat_w(ACC_W'(r_org[k])
                                            - ACC_W'(row_word(r_vtx[0], 2'(k))));
                end
                n_step = '0;
            end
            S_CALC: begin
                // The step counter parks on the last micro-op so it never
                // addresses past the end of the program.
                if (r_step != UC_W'(UC_LEN - 1)) begin
                    n_step = r_step + 1'b1;
                end
                case (uop.act)
                    ACT_LOAD:   n_acc = ACC_W'(r_prod);
                    ACT_MINOR:  n_rf[uop.dst] = sat_w((r_acc - ACC_W'(r_prod)) >>> FRAC_BITS);
                    ACT_DFIRST: n_acc = ACC_W'(qm);
                    ACT_DADD:   n_acc = r_acc + ACC_W'(qm);
                    ACT_DLAST:  n_rf[uop.dst] = sat_w(r_acc + ACC_W'(qm));
                    default:    n_acc = r_acc;
                endcase
                n_divk    = '0;
                n_div_run = 1'b0;
                if (r_step == UC_W'(UC_LEN - 1) && det_zero && !last_tri) begin
                    n_tri  = r_tri + 1'b1;
                    n_base = r_base + ADDR_W'(3);
                    n_rdk  = '0;
                end
            end
            S_DIV: begin
                if (div_start) begin
                    n_div_run = 1'b1;
                end
                if (div_done) begin
                    n_quo[r_divk] = div_quo;
                    n_divk        = r_divk + 1'b1;
                    n_div_run     = 1'b0;
                end
            end
            S_CMP: begin
                if (hit_ok) begin
                    n_rf[RF_BEST] = r_quo[0];
                    n_bidx        = r_tri;
                    n_found       = 1'b1;
                end
                if (!last_tri) begin
                    n_tri  = r_tri + 1'b1;
                    n_base = r_base + ADDR_W'(3);
                    n_rdk  = '0;
                end
            end
            S_HP: begin
                n_hp = r_hp + 1'b1;
                if (r_hp != '0) begin
                    n_hit[r_hp - 1'b1] = sat_w(ACC_W'(r_org[r_hp - 1'b1]) + ACC_W'(qm));
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid        = 1'b1;
                    n_out.hit          = r_found;
                    n_out.hit_index    = r_found ? r_bidx : '0;
                    n_out.hit_distance = r_found ? r_rf[RF_BEST][WORD_W-2:0] : '0;
                    n_out.hit_x        = r_found ? r_hit[0] : '0;
                    n_out.hit_y        = r_found ? r_hit[1] : '0;
                    n_out.hit_z        = r_found ? r_hit[2] : '0;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_div_run   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_div_run   <= n_div_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_tri   <= n_tri;
        r_base  <= n_base;
        r_rdk   <= n_rdk;
        r_step  <= n_step;
        r_divk  <= n_divk;
        r_hp    <= n_hp;
        r_found <= n_found;
        r_bidx  <= n_bidx;
        r_org   <= n_org;
        r_hit   <= n_hit;
        r_quo   <= n_quo;
        r_vtx   <= n_vtx;
        r_rf    <= n_rf;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_out   <= n_out;
    end

    // The triangle walk never steps past the clamped count.
    `RTCH_ASSERT_IMP(a_tri_in_range, i_clk, i_rst_n, r_state == S_CALC, CNT_W'(r_tri) < r_n)
    // A recorded hit always has a strictly positive distance.
    `RTCH_ASSERT_IMP(a_best_positive, i_clk, i_rst_n, r_found && r_state == S_DONE, r_rf[RF_BEST] > 0)
    // Leaving the result state always presents a transaction.
    `RTCH_ASSERT_NXT(a_done_presents, i_clk, i_rst_n, out_load, o_valid && r_state == S_IDLE)

endmodule

[hdl/rtch_store.sv]
// Vertex store: one row per triangle corner holding z, y and x.
// Depends on rtch_pkg; registered read, no reset.
module rtch_store (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [rtch_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [rtch_pkg::ROW_W-1:0]   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [rtch_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [rtch_pkg::ROW_W-1:0]   o_rd_data
);
    import rtch_pkg::*;

    logic [ROW_W-1:0] r_mem [ROWS];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/rtch_div.sv]
// Radix-2 restoring divider: saturate((num * 2^FRAC_BITS) / den), truncated.
// Depends on rtch_pkg; one quotient bit per cycle.
module rtch_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [rtch_pkg::WORD_W-1:0] i_num,
    input  logic signed [rtch_pkg::WORD_W-1:0] i_den,
    output logic                               o_done,
    output logic signed [rtch_pkg::WORD_W-1:0] o_quo
);
    import rtch_pkg::*;

    localparam int CNT_BITS = $clog2(DVD_W);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [WORD_W:0]     r_rem, n_rem;
    logic [DVD_W-1:0]    r_dvd, n_dvd;
    logic [WORD_W-1:0]   r_dsr, n_dsr;
    logic                r_neg, n_neg;
    logic [WORD_W:0]     rem_sh;
    logic [WORD_W-1:0]   num_mag;
    logic [WORD_W-1:0]   den_mag;

    always_comb begin
        num_mag = i_num[WORD_W-1] ? (~i_num + 1'b1) : i_num;
        den_mag = i_den[WORD_W-1] ? (~i_den + 1'b1) : i_den;
        rem_sh  = {r_rem[WORD_W-1:0], r_dvd[DVD_W-1]};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_dsr   = r_dsr;
        n_neg   = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = {num_mag, {FRAC_BITS{1'b0}}};
            n_dsr  = den_mag;
            n_neg  = i_num[WORD_W-1] ^ i_den[WORD_W-1];
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dsr}) begin
                n_rem = rem_sh - {1'b0, r_dsr};
                n_dvd = {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_neg <= n_neg;
    end

    // The quotient magnitude sits in the dividend shifter once done.
    always_comb begin
        if (!r_neg) begin
            o_quo = (r_dvd > DVD_W'(W_MAX)) ? WORD_W'(W_MAX) : r_dvd[WORD_W-1:0];
        end else if (r_dvd > DVD_W'(W_MAX) + 1'b1) begin
            o_quo = WORD_W'(W_MIN);
        end else begin
            o_quo = ~r_dvd[WORD_W-1:0] + 1'b1;
        end
    end

    assign o_done = r_done;

endmodule
